[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define CHK_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[src/tmss_pkg.sv]
// ----------------------------------------------------------------------------
// tmss_pkg
// Types, sizes and codes shared by the template matcher modules.
// ----------------------------------------------------------------------------
package tmss_pkg;

    localparam int MAX_SRC_COLS  = 1024;
    localparam int MAX_SRC_ROWS  = 1024;
    localparam int MAX_TMPL_COLS = 64;
    localparam int MAX_TMPL_ROWS = 64;

    localparam int TMPL_DEPTH = MAX_TMPL_COLS * MAX_TMPL_ROWS;
    localparam int SRC_DEPTH  = MAX_SRC_COLS * MAX_SRC_ROWS;
    localparam int TADDR_W    = $clog2(TMPL_DEPTH);
    localparam int SADDR_W    = $clog2(SRC_DEPTH);
    localparam int TPTR_W     = TADDR_W + 1;
    localparam int SPTR_W     = SADDR_W + 1;

    localparam int PIX_W     = 8;
    localparam int POS_W     = 10;
    localparam int LIM_W     = 11;
    localparam int TSZ_W     = 7;
    localparam int TERM_W    = 2 * PIX_W;
    localparam int SCORE_W   = 28;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic SQDIFF = 1'b0;
    localparam logic SADIFF = 1'b1;

    localparam logic ACT_TEMPLATE = 1'b0;
    localparam logic ACT_SOURCE   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METHOD    = 3'd0,
        CFG_SRC_COLS  = 3'd1,
        CFG_TMPL_ROWS = 3'd2,
        CFG_TMPL_COLS = 3'd3,
        CFG_ROW_BEGIN = 3'd4,
        CFG_COL_BEGIN = 3'd5,
        CFG_ROW_LIMIT = 3'd6,
        CFG_COL_LIMIT = 3'd7
    } cfg_idx_t;

    // Search settings after saturation.
    typedef struct packed {
        logic             method;
        logic [LIM_W-1:0] pitch;
        logic [TSZ_W-1:0] th;
        logic [TSZ_W-1:0] tw;
        logic [POS_W-1:0] row_begin;
        logic [POS_W-1:0] col_begin;
        logic [LIM_W-1:0] rl;
        logic [LIM_W-1:0] cl;
    } cfg_t;

    // One command from the front to the back.
    typedef struct packed {
        logic               tmpl_we;
        logic               src_we;
        logic               search;
        logic [SADDR_W-1:0] addr;
        logic [PIX_W-1:0]   data;
    } cmd_t;

endpackage

[src/tmss_front.sv]
// ----------------------------------------------------------------------------
// tmss_front
// Accepts pixel items, keeps the write pointers and turns each item into a
// store command; the source item marked last also carries a search.
// ----------------------------------------------------------------------------
module tmss_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    action,
    input  logic [tmss_pkg::PIX_W-1:0] pixel,
    input  logic                    last,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output tmss_pkg::cmd_t          cmd
);
    import tmss_pkg::*;

    logic [TPTR_W-1:0] tptr_reg, tptr_next;
    logic [SPTR_W-1:0] sptr_reg, sptr_next;
    logic              tmpl_room;
    logic              src_room;
    logic              take;

    assign tmpl_room = (tptr_reg < TPTR_W'(TMPL_DEPTH));
    assign src_room  = (sptr_reg < SPTR_W'(SRC_DEPTH));
    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign take      = in_valid && cmd_ready;

    always_comb
    begin
        cmd.data    = pixel;
        cmd.tmpl_we = 1'b0;
        cmd.src_we  = 1'b0;
        cmd.search  = 1'b0;
        cmd.addr    = '0;
        tptr_next   = tptr_reg;
        sptr_next   = sptr_reg;
        if (action == ACT_TEMPLATE)
        begin
            cmd.tmpl_we = tmpl_room;
            cmd.addr    = SADDR_W'(tptr_reg[TADDR_W-1:0]);
            if (tmpl_room)
            begin
                tptr_next = tptr_reg + TPTR_W'(1);
            end
        end
        else
        begin
            cmd.src_we = src_room;
            cmd.search = last;
            cmd.addr   = sptr_reg[SADDR_W-1:0];
            if (last)
            begin
                tptr_next = '0;
                sptr_next = '0;
            end
            else if (src_room)
            begin
                sptr_next = sptr_reg + SPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tptr_reg <= '0;
            sptr_reg <= '0;
        end
        else if (take)
        begin
            tptr_reg <= tptr_next;
            sptr_reg <= sptr_next;
        end
    end

endmodule

[src/tmss_queue.sv]
// ----------------------------------------------------------------------------
// tmss_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module tmss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tmss_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tmss_pkg::cmd_t pop_cmd
);
    import tmss_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_cmd    = mem_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

[src/tmss_back.sv]
// ----------------------------------------------------------------------------
// tmss_back
// Holds the pixel stores, writes them and runs the placement search with a
// pipelined difference and accumulate path.
// ----------------------------------------------------------------------------
module tmss_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tmss_pkg::cfg_t              cfg,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  tmss_pkg::cmd_t              cmd,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [tmss_pkg::POS_W-1:0]   best_row,
    output logic [tmss_pkg::POS_W-1:0]   best_col,
    output logic [tmss_pkg::SCORE_W-1:0] best_score
);
    import tmss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_RUN,
        ST_DRAIN
    } state_t;

    logic [PIX_W-1:0] tmem [TMPL_DEPTH];
    logic [PIX_W-1:0] smem [SRC_DEPTH];

    state_t             state_reg;
    logic [LIM_W-1:0]   r_reg;
    logic [LIM_W-1:0]   c_reg;
    logic [TSZ_W-1:0]   m_reg;
    logic [TSZ_W-1:0]   n_reg;
    logic [TADDR_W-1:0] ta_reg;
    logic [SADDR_W-1:0] sa_reg;
    logic [SADDR_W-1:0] rowst_reg;
    logic [SADDR_W-1:0] rb_reg;
    logic               out_valid_reg;
    logic               found_out_reg;
    logic [POS_W-1:0]   row_out_reg;
    logic [POS_W-1:0]   col_out_reg;
    logic [SCORE_W-1:0] score_out_reg;

    logic [PIX_W-1:0]   t_rd_reg;
    logic [PIX_W-1:0]   s_rd_reg;
    logic               v1_reg, f1_reg, l1_reg;
    logic [POS_W-1:0]   r1_reg, c1_reg;
    logic               v2_reg, f2_reg, l2_reg;
    logic [POS_W-1:0]   r2_reg, c2_reg;
    logic [TERM_W-1:0]  term_reg;
    logic [SCORE_W-1:0] acc_reg;
    logic               bfound_reg;
    logic [POS_W-1:0]   brow_reg;
    logic [POS_W-1:0]   bcol_reg;
    logic [SCORE_W-1:0] bscore_reg;

    logic                  pop;
    logic                  issue;
    logic                  first_el;
    logic                  last_el;
    logic                  row_end;
    logic                  col_more;
    logic                  row_more;
    logic [PIX_W-1:0]      diff;
    logic [TERM_W-1:0]     term;
    logic [SCORE_W-1:0]    sum;
    logic [2*LIM_W-1:0]    prod;
    logic [SADDR_W-1:0]    rb_step;

    assign cmd_ready  = (state_reg == ST_IDLE) && !(cmd.search && out_valid_reg);
    assign pop        = cmd_valid && cmd_ready;
    assign issue      = (state_reg == ST_RUN);
    assign first_el   = (m_reg == '0) && (n_reg == '0);
    assign row_end    = (n_reg == cfg.tw - TSZ_W'(1));
    assign last_el    = row_end && (m_reg == cfg.th - TSZ_W'(1));
    assign col_more   = (c_reg + LIM_W'(1)) < cfg.cl;
    assign row_more   = (r_reg + LIM_W'(1)) < cfg.rl;
    assign prod       = (2*LIM_W)'(cfg.row_begin) * (2*LIM_W)'(cfg.pitch);
    assign rb_step    = rb_reg + SADDR_W'(cfg.pitch);

    assign out_valid  = out_valid_reg;
    assign found      = found_out_reg;
    assign best_row   = row_out_reg;
    assign best_col   = col_out_reg;
    assign best_score = score_out_reg;

    always_ff @(posedge clk)
    begin
        if (pop && cmd.tmpl_we)
        begin
            tmem[cmd.addr[TADDR_W-1:0]] <= cmd.data;
        end
        t_rd_reg <= tmem[ta_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pop && cmd.src_we)
        begin
            smem[cmd.addr] <= cmd.data;
        end
        s_rd_reg <= smem[sa_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            found_out_reg <= 1'b0;
            row_out_reg   <= '0;
            col_out_reg   <= '0;
            score_out_reg <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            m_reg         <= '0;
            n_reg         <= '0;
            ta_reg        <= '0;
            sa_reg        <= '0;
            rowst_reg     <= '0;
            rb_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop && cmd.search)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    rb_reg    <= prod[SADDR_W-1:0];
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    r_reg     <= LIM_W'(cfg.row_begin);
                    c_reg     <= LIM_W'(cfg.col_begin);
                    m_reg     <= '0;
                    n_reg     <= '0;
                    ta_reg    <= '0;
                    sa_reg    <= rb_reg + SADDR_W'(cfg.col_begin);
                    rowst_reg <= rb_reg + SADDR_W'(cfg.col_begin);
                    if ((cfg.rl <= LIM_W'(cfg.row_begin)) ||
                        (cfg.cl <= LIM_W'(cfg.col_begin)))
                    begin
                        out_valid_reg <= 1'b1;
                        found_out_reg <= 1'b0;
                        row_out_reg   <= '0;
                        col_out_reg   <= '0;
                        score_out_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end
                    else if ((cfg.th == '0) || (cfg.tw == '0))
                    begin
                        // An empty template scores zero everywhere.
                        out_valid_reg <= 1'b1;
                        found_out_reg <= 1'b1;
                        row_out_reg   <= cfg.row_begin;
                        col_out_reg   <= cfg.col_begin;
                        score_out_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (!row_end)
                    begin
                        n_reg  <= n_reg + TSZ_W'(1);
                        ta_reg <= ta_reg + TADDR_W'(1);
                        sa_reg <= sa_reg + SADDR_W'(1);
                    end
                    else if (!last_el)
                    begin
                        m_reg     <= m_reg + TSZ_W'(1);
                        n_reg     <= '0;
                        ta_reg    <= ta_reg + TADDR_W'(1);
                        sa_reg    <= rowst_reg + SADDR_W'(cfg.pitch);
                        rowst_reg <= rowst_reg + SADDR_W'(cfg.pitch);
                    end
                    else
                    begin
                        m_reg  <= '0;
                        n_reg  <= '0;
                        ta_reg <= '0;
                        if (col_more)
                        begin
                            c_reg     <= c_reg + LIM_W'(1);
                            sa_reg    <= rb_reg + SADDR_W'(c_reg + LIM_W'(1));
                            rowst_reg <= rb_reg + SADDR_W'(c_reg + LIM_W'(1));
                        end
                        else if (row_more)
                        begin
                            r_reg     <= r_reg + LIM_W'(1);
                            c_reg     <= LIM_W'(cfg.col_begin);
                            rb_reg    <= rb_step;
                            sa_reg    <= rb_step + SADDR_W'(cfg.col_begin);
                            rowst_reg <= rb_step + SADDR_W'(cfg.col_begin);
                        end
                        else
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        found_out_reg <= bfound_reg;
                        row_out_reg   <= brow_reg;
                        col_out_reg   <= bcol_reg;
                        score_out_reg <= bscore_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign diff = (t_rd_reg > s_rd_reg) ? (t_rd_reg - s_rd_reg) : (s_rd_reg - t_rd_reg);
    assign term = (cfg.method == SADIFF) ? TERM_W'(diff) : (TERM_W'(diff) * TERM_W'(diff));
    assign sum  = f2_reg ? SCORE_W'(term_reg) : (acc_reg + SCORE_W'(term_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            bfound_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (state_reg == ST_MUL)
            begin
                bfound_reg <= 1'b0;
            end
            else if (v2_reg && l2_reg && (!bfound_reg || (sum < bscore_reg)))
            begin
                bfound_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg   <= first_el;
        l1_reg   <= last_el;
        r1_reg   <= r_reg[POS_W-1:0];
        c1_reg   <= c_reg[POS_W-1:0];
        f2_reg   <= f1_reg;
        l2_reg   <= l1_reg;
        r2_reg   <= r1_reg;
        c2_reg   <= c1_reg;
        term_reg <= term;
        if (v2_reg)
        begin
            acc_reg <= sum;
        end
        if (v2_reg && l2_reg && (!bfound_reg || (sum < bscore_reg)))
        begin
            bscore_reg <= sum;
            brow_reg   <= r2_reg;
            bcol_reg   <= c2_reg;
        end
    end

endmodule

[src/template_match_ssd_sad_core.sv]
// ----------------------------------------------------------------------------
// template_match_ssd_sad_core
// Template matcher by sum of squared or absolute differences.
// ----------------------------------------------------------------------------
// Pixel items load at one per cycle into the template and source memories.
// The source item marked last starts a full search of the window; while it
// runs, pixel items queue and then stall. A search visits every placement in
// the window and, at each, every template pixel, one template pixel per cycle,
// set by the single read port of the source memory. An empty window or
// template answers from the start state, without the difference path.
// Configuration writes are taken in any cycle.
module template_match_ssd_sad_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tmss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmss_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [tmss_pkg::PIX_W-1:0]    pixel,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [tmss_pkg::POS_W-1:0]    best_row,
    output logic [tmss_pkg::POS_W-1:0]    best_col,
    output logic [tmss_pkg::SCORE_W-1:0]  best_score
);
    import tmss_pkg::*;

    logic             method_reg;
    logic [LIM_W-1:0] src_cols_reg;
    logic [TSZ_W-1:0] tmpl_rows_reg;
    logic [TSZ_W-1:0] tmpl_cols_reg;
    logic [POS_W-1:0] row_begin_reg;
    logic [POS_W-1:0] col_begin_reg;
    logic [LIM_W-1:0] row_limit_reg;
    logic [LIM_W-1:0] col_limit_reg;
    cfg_t             cfg;
    logic             fq_valid, fq_ready;
    cmd_t             fq_cmd;
    logic             qb_valid, qb_ready;
    cmd_t             qb_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg    <= SQDIFF;
            src_cols_reg  <= LIM_W'(MAX_SRC_COLS);
            tmpl_rows_reg <= TSZ_W'(1);
            tmpl_cols_reg <= TSZ_W'(1);
            row_begin_reg <= '0;
            col_begin_reg <= '0;
            row_limit_reg <= LIM_W'(MAX_SRC_ROWS);
            col_limit_reg <= LIM_W'(MAX_SRC_COLS);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_METHOD:    method_reg    <= cfg_data[0];
                CFG_SRC_COLS:  src_cols_reg  <= cfg_data[LIM_W-1:0];
                CFG_TMPL_ROWS: tmpl_rows_reg <= cfg_data[TSZ_W-1:0];
                CFG_TMPL_COLS: tmpl_cols_reg <= cfg_data[TSZ_W-1:0];
                CFG_ROW_BEGIN: row_begin_reg <= cfg_data[POS_W-1:0];
                CFG_COL_BEGIN: col_begin_reg <= cfg_data[POS_W-1:0];
                CFG_ROW_LIMIT: row_limit_reg <= cfg_data[LIM_W-1:0];
                CFG_COL_LIMIT: col_limit_reg <= cfg_data[LIM_W-1:0];
                default:       method_reg    <= method_reg;
            endcase
        end
    end

    // Oversized settings saturate at the store sizes.
    always_comb
    begin
        cfg.method    = method_reg;
        cfg.pitch     = (src_cols_reg > LIM_W'(MAX_SRC_COLS)) ?
                        LIM_W'(MAX_SRC_COLS) : src_cols_reg;
        cfg.th        = (tmpl_rows_reg > TSZ_W'(MAX_TMPL_ROWS)) ?
                        TSZ_W'(MAX_TMPL_ROWS) : tmpl_rows_reg;
        cfg.tw        = (tmpl_cols_reg > TSZ_W'(MAX_TMPL_COLS)) ?
                        TSZ_W'(MAX_TMPL_COLS) : tmpl_cols_reg;
        cfg.row_begin = row_begin_reg;
        cfg.col_begin = col_begin_reg;
        cfg.rl        = (row_limit_reg > LIM_W'(MAX_SRC_ROWS)) ?
                        LIM_W'(MAX_SRC_ROWS) : row_limit_reg;
        cfg.cl        = (col_limit_reg > LIM_W'(MAX_SRC_COLS)) ?
                        LIM_W'(MAX_SRC_COLS) : col_limit_reg;
    end

    tmss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .pixel     (pixel),
        .last      (last),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    tmss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    tmss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd_valid  (qb_valid),
        .cmd_ready  (qb_ready),
        .cmd        (qb_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .best_row   (best_row),
        .best_col   (best_col),
        .best_score (best_score)
    );

endmodule

[src/tmss_checker.sv]
// ----------------------------------------------------------------------------
// tmss_checker
// Port-level checks on the template matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmss_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          found,
    input logic [tmss_pkg::POS_W-1:0]    best_row,
    input logic [tmss_pkg::POS_W-1:0]    best_col,
    input logic [tmss_pkg::SCORE_W-1:0]  best_score
);
    import tmss_pkg::*;

    logic [SCORE_W-1:0] score_bound;

    // The largest sum a full template of squared differences can reach.
    assign score_bound = SCORE_W'(TMPL_DEPTH * 255 * 255);

    `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result item dropped while stalled")
    `CHK_ASSERT(a_empty_zero, clk, rst_n, out_valid && !found |-> (best_row == '0) && (best_col == '0) && (best_score == '0), "empty search must report zeros")
    `CHK_ASSERT(a_score_bound, clk, rst_n, out_valid |-> best_score <= score_bound, "score beyond reachable bound")
    `CHK_ASSERT(a_cfg_open, clk, rst_n, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind template_match_ssd_sad_core tmss_checker u_chk (.*);
